### rtl/core/voxel_occupancy_marker_assert.svh
// Assertion macros for the voxel occupancy marker
`ifndef VOXEL_OCCUPANCY_MARKER_ASSERT_SVH
`define VOXEL_OCCUPANCY_MARKER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define VOM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define VOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vom_pkg.sv
package vom_pkg;

    // Command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Fixed arithmetic widths
    localparam int CW      = 14;  // signed cell coordinate
    localparam int DW      = 33;  // offset times normal
    localparam int VW      = 35;  // coordinate in Q.30
    localparam int PW      = 44;  // scaled coordinate
    localparam int FRAC    = 30;
    localparam int NW      = 22;  // cell number and occupied total
    localparam int QDEPTH  = 2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        point_x;
        logic [15:0]        point_y;
        logic [15:0]        point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [6:0]         query_i;
        logic [6:0]         query_j;
        logic [6:0]         query_k;
    } item_t;

    typedef struct packed {
        logic [NW-1:0] cell_number;
        logic [NW-1:0] occupied_total;
        logic          out_of_range;
    } result_t;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t [2:0] vec_t;

    // One classified command handed from front to back
    typedef struct packed {
        logic [1:0]   cmd;
        vec_t [2:0]   corner;
        logic [6:0]   query_i;
        logic [6:0]   query_j;
        logic [6:0]   query_k;
    } job_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

### rtl/core/vom_front.sv
module vom_front #(
    parameter int AXIS_STEPS = 100
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  vom_pkg::item_t        item,
    input  logic [15:0]           norm_offset,
    input  vom_pkg::back_status_t status,
    input  logic                  q_full,
    output logic                  q_push,
    output vom_pkg::job_t         q_job
);
    import vom_pkg::*;

    localparam logic signed [8:0] STEP = 9'(AXIS_STEPS - 3);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_SCALE, F_PUSH} fstate_t;
    typedef logic signed [DW-1:0] offs_t;
    typedef logic signed [PW-1:0] prod_t;

    fstate_t state_reg, state_next;
    item_t   item_reg, item_next;
    offs_t   d_reg [3];
    offs_t   d_next [3];
    prod_t   s_reg [3][3];
    prod_t   s_next [3][3];

    logic [15:0]        pt [3];
    logic signed [15:0] nm [3];
    logic signed [VW-1:0] v0, v1, v2;
    job_t job;

    assign pt[0] = item_reg.point_x;
    assign pt[1] = item_reg.point_y;
    assign pt[2] = item_reg.point_z;
    assign nm[0] = item_reg.normal_x;
    assign nm[1] = item_reg.normal_y;
    assign nm[2] = item_reg.normal_z;

    assign item_stall = (state_reg != F_IDLE) || status.clearing;
    assign q_push     = (state_reg == F_PUSH) && !q_full;
    assign q_job      = job;

    // Floor each scaled coordinate to a cell corner
    always_comb
    begin
        job         = '0;
        job.cmd     = item_reg.cmd;
        job.query_i = item_reg.query_i;
        job.query_j = item_reg.query_j;
        job.query_k = item_reg.query_k;
        for (int p = 0; p < 3; p++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                job.corner[p][ax] = CW'(s_reg[p][ax] >>> FRAC) + coord_t'(1);
            end
        end
    end

    // Advance the front sequencer
    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        d_next     = d_reg;
        s_next     = s_reg;
        v0 = '0;
        v1 = '0;
        v2 = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (item_valid && !item_stall)
                begin
                    item_next  = item;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    d_next[ax] = DW'($signed({1'b0, norm_offset})) * DW'(nm[ax]);
                end
                state_next = F_SCALE;
            end
            F_SCALE:
            begin
                for (int ax = 0; ax < 3; ax++)
                begin
                    v0 = $signed({{(VW - 30){1'b0}}, pt[ax], 14'd0});
                    v1 = v0 + VW'(d_reg[ax]);
                    v2 = v0 - (VW'(d_reg[ax]) <<< 1);
                    s_next[0][ax] = PW'(v0) * PW'(STEP);
                    s_next[1][ax] = PW'(v1) * PW'(STEP);
                    s_next[2][ax] = PW'(v2) * PW'(STEP);
                end
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Hold state and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        d_reg    <= d_next;
        s_reg    <= s_next;
    end

endmodule

### rtl/core/vom_queue.sv
module vom_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vom_pkg::job_t push_job,
    input  logic          pop,
    output vom_pkg::job_t head,
    output logic          full,
    output logic          empty
);
    import vom_pkg::*;

    localparam int PTRW = $clog2(QDEPTH);

    job_t            entry_reg [QDEPTH];
    logic [PTRW-1:0] wr_reg, rd_reg;
    logic [PTRW:0]   fill_reg;

    assign head  = entry_reg[rd_reg];
    assign full  = (fill_reg == (PTRW + 1)'(QDEPTH));
    assign empty = (fill_reg == '0);

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PTRW + 1)'(push) - (PTRW + 1)'(pop);
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

endmodule

### rtl/core/vom_back.sv
module vom_back #(
    parameter int GRID_SIZE = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vom_pkg::job_t         q_head,
    input  logic                  q_empty,
    output logic                  q_pop,
    output vom_pkg::back_status_t status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output vom_pkg::result_t      result
);
    import vom_pkg::*;
    `include "voxel_occupancy_marker_assert.svh"

    localparam int IW   = $clog2(GRID_SIZE);
    localparam int ROWS = GRID_SIZE * GRID_SIZE;
    localparam int RW   = $clog2(ROWS);
    localparam int PCW  = $clog2(GRID_SIZE + 1);

    typedef enum logic [2:0] {
        B_CLR, B_IDLE, B_ROW, B_WR, B_QCHK, B_QTEST, B_QWALK, B_DONE
    } bstate_t;

    function automatic logic [PCW-1:0] popcnt(input logic [GRID_SIZE-1:0] v);
        logic [PCW-1:0] n;
        n = '0;
        for (int b = 0; b < GRID_SIZE; b++)
        begin
            n = n + PCW'(v[b]);
        end
        return n;
    endfunction

    bstate_t        state_reg, state_next;
    job_t           job_reg, job_next;
    logic [1:0]     blk_reg, blk_next, a_reg, a_next, b_reg, b_next;
    logic           flag_reg, flag_next, clr_cmd_reg, clr_cmd_next;
    logic [NW-1:0]  num_reg, num_next, count_reg, count_next, acc_reg, acc_next;
    logic [RW-1:0]  ptr_reg, ptr_next, tgt_reg, tgt_next;
    logic           rv_reg, rv_next, pcv_reg, pcv_next;
    logic [PCW-1:0] pc_reg, pc_next;
    logic           res_valid_reg, res_valid_next;
    result_t        res_reg, res_next;

    logic [GRID_SIZE-1:0] mem [ROWS];
    logic [GRID_SIZE-1:0] rdata_reg;
    logic [RW-1:0]        raddr, waddr;
    logic                 we;
    logic [GRID_SIZE-1:0] wdata;

    vec_t                 cur;
    coord_t               ci, cj, kk;
    logic                 row_in, kdrop;
    logic [GRID_SIZE-1:0] kmask, lowmask;
    logic [RW-1:0]        row_addr, head_tgt;
    logic [IW-1:0]        kq;
    logic                 add_last, head_in;

    // Locate the current row of the current block
    always_comb
    begin
        cur    = job_reg.corner[blk_reg];
        ci     = cur[0] + coord_t'(a_reg);
        cj     = cur[1] + coord_t'(b_reg);
        row_in = (ci >= 0) && (ci < coord_t'(GRID_SIZE))
              && (cj >= 0) && (cj < coord_t'(GRID_SIZE));
        row_addr = RW'(ci[IW-1:0]) * RW'(GRID_SIZE) + RW'(cj[IW-1:0]);
        kmask = '0;
        kdrop = 1'b0;
        kk    = '0;
        for (int c = 0; c < 4; c++)
        begin
            kk = cur[2] + coord_t'(c);
            if ((kk >= 0) && (kk < coord_t'(GRID_SIZE)))
            begin
                kmask[kk[IW-1:0]] = 1'b1;
            end
            else
            begin
                kdrop = 1'b1;
            end
        end
        add_last = (blk_reg == 2'd2) && (a_reg == 2'd3) && (b_reg == 2'd3);
    end

    // Decode the query cell
    always_comb
    begin
        head_in  = (int'(q_head.query_i) < GRID_SIZE) && (int'(q_head.query_j) < GRID_SIZE)
                && (int'(q_head.query_k) < GRID_SIZE);
        head_tgt = RW'(IW'(q_head.query_i)) * RW'(GRID_SIZE) + RW'(IW'(q_head.query_j));
        kq       = IW'(job_reg.query_k);
        lowmask  = ({{(GRID_SIZE - 1){1'b0}}, 1'b1} << kq) - {{(GRID_SIZE - 1){1'b0}}, 1'b1};
    end

    assign q_pop           = (state_reg == B_IDLE) && !q_empty;
    assign status.clearing = (state_reg == B_CLR);
    assign result_valid    = res_valid_reg;
    assign result          = res_reg;

    // Sequence the grid operations
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        blk_next       = blk_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        flag_next      = flag_reg;
        clr_cmd_next   = clr_cmd_reg;
        num_next       = num_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        ptr_next       = ptr_reg;
        tgt_next       = tgt_reg;
        rv_next        = 1'b0;
        pcv_next       = 1'b0;
        pc_next        = pc_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        raddr          = ptr_reg;
        waddr          = ptr_reg;
        we             = 1'b0;
        wdata          = '0;

        // Drop the result word once taken
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            B_CLR:
            begin
                we       = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == RW'(ROWS - 1))
                begin
                    state_next = clr_cmd_reg ? B_DONE : B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next  = q_head;
                    num_next  = '0;
                    flag_next = 1'b0;
                    blk_next  = '0;
                    a_next    = '0;
                    b_next    = '0;
                    case (q_head.cmd)
                        CMD_ADD:
                        begin
                            state_next = B_ROW;
                        end
                        CMD_QUERY:
                        begin
                            tgt_next   = head_tgt;
                            state_next = head_in ? B_QCHK : B_DONE;
                        end
                        CMD_CLEAR:
                        begin
                            count_next   = '0;
                            ptr_next     = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = B_CLR;
                        end
                        default:
                        begin
                            state_next = B_DONE;
                        end
                    endcase
                end
            end
            B_ROW:
            begin
                raddr     = row_addr;
                flag_next = flag_reg | !row_in | kdrop;
                if (row_in)
                begin
                    state_next = B_WR;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                    if (b_reg == 2'd3)
                    begin
                        a_next = a_reg + 1'b1;
                        if (a_reg == 2'd3)
                        begin
                            blk_next = blk_reg + 1'b1;
                        end
                    end
                    if (add_last)
                    begin
                        state_next = B_DONE;
                    end
                end
            end
            B_WR:
            begin
                we         = 1'b1;
                waddr      = row_addr;
                wdata      = rdata_reg | kmask;
                count_next = count_reg + NW'(popcnt(kmask & ~rdata_reg));
                b_next     = b_reg + 1'b1;
                if (b_reg == 2'd3)
                begin
                    a_next = a_reg + 1'b1;
                    if (a_reg == 2'd3)
                    begin
                        blk_next = blk_reg + 1'b1;
                    end
                end
                state_next = add_last ? B_DONE : B_ROW;
            end
            B_QCHK:
            begin
                raddr      = tgt_reg;
                state_next = B_QTEST;
            end
            B_QTEST:
            begin
                acc_next = NW'(popcnt(rdata_reg & lowmask));
                ptr_next = '0;
                if (!rdata_reg[kq])
                begin
                    state_next = B_DONE;
                end
                else if (tgt_reg == '0)
                begin
                    num_next   = NW'(popcnt(rdata_reg & lowmask)) + 1'b1;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_QWALK;
                end
            end
            B_QWALK:
            begin
                raddr = ptr_reg;
                if (ptr_reg != tgt_reg)
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rv_next  = 1'b1;
                end
                if (rv_reg)
                begin
                    pc_next  = popcnt(rdata_reg);
                    pcv_next = 1'b1;
                end
                if (pcv_reg)
                begin
                    acc_next = acc_reg + NW'(pc_reg);
                end
                if ((ptr_reg == tgt_reg) && !rv_reg && !pcv_reg)
                begin
                    num_next   = acc_reg + 1'b1;
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next          = 1'b1;
                    res_next.cell_number    = num_reg;
                    res_next.occupied_total = count_reg;
                    res_next.out_of_range   = flag_reg;
                    clr_cmd_next            = 1'b0;
                    state_next              = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            ptr_reg       <= '0;
            clr_cmd_reg   <= 1'b0;
            count_reg     <= '0;
            rv_reg        <= 1'b0;
            pcv_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            clr_cmd_reg   <= clr_cmd_next;
            count_reg     <= count_next;
            rv_reg        <= rv_next;
            pcv_reg       <= pcv_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        blk_reg  <= blk_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        flag_reg <= flag_next;
        num_reg  <= num_next;
        acc_reg  <= acc_next;
        tgt_reg  <= tgt_next;
        pc_reg   <= pc_next;
        res_reg  <= res_next;
    end

    // Occupancy rows, one row of k per (i, j)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    `VOM_ASSERT_IMPL(a_write_only_mark_or_clear, we,
        (state_reg == B_WR) || (state_reg == B_CLR), "grid written outside mark or clear")
    `VOM_ASSERT_IMPL(a_count_zero_in_clear, state_reg == B_CLR,
        count_reg == '0, "occupied total not zero while clearing")
    `VOM_ASSERT_NEXT(a_walk_keeps_count, (state_reg == B_QWALK) && (state_next == B_QWALK),
        $stable(count_reg), "occupied total moved during query walk")
    `VOM_ASSERT_IMPL(a_pop_needs_word, q_pop,
        !q_empty && (state_reg == B_IDLE), "job taken from empty queue")

endmodule

### rtl/core/voxel_occupancy_marker.sv
// Channel   Direction  Handshake                   Word
// item      in         item_valid / item_stall     vom_pkg::item_t
// result    out        result_valid / result_stall vom_pkg::result_t
// apb       in/out     psel, penable, pready       norm_offset at byte address 0
//
// Front: each item passes capture, offset multiply, scale and enqueue; the next is taken after.
// Add: each in-grid row of the 48 rows is read and then written back, a dropped row is only
//   skipped; each mark is a read-modify-write of one row of the row memory.
// Query of a set cell: read the target row, then walk and count every row before it (no walk when i and j are zero).
// Reset and clear sweep all GRID_SIZE*GRID_SIZE rows, item_stall high.
// A stalled result holds the back only once the next result is ready; then the queue fills.
module voxel_occupancy_marker #(
    parameter int GRID_SIZE  = 128,
    parameter int AXIS_STEPS = 100
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  vom_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output vom_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vom_pkg::*;

    logic [15:0]  offset_reg;
    logic         q_push, q_pop, q_full, q_empty;
    job_t         q_job, q_head;
    back_status_t status;

    // Register file: norm_offset only
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {16'd0, offset_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 16'd655;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            offset_reg <= pwdata[15:0];
        end
    end

    vom_front #(
        .AXIS_STEPS (AXIS_STEPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .norm_offset (offset_reg),
        .status      (status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (q_job)
    );

    vom_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    vom_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vom_pkg::*;

    localparam int GRID  = 128;
    localparam int STEPS = 100;
    localparam int WORDS = GRID * GRID * GRID / 64;
    localparam logic [2:0] ADDR_OFFSET = 3'd0;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    voxel_occupancy_marker #(
        .GRID_SIZE  (GRID),
        .AXIS_STEPS (STEPS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Shadow of the grid, the count and the offset register
    bit [63:0]   occ_words [WORDS];
    int unsigned occ_count;
    logic [15:0] offset_dist;

    item_t       pending_words [$];
    result_t     expected_results [$];
    int          add_cells [$][3];
    int          errors;
    bit          calm;
    bit          hold_request;
    int          send_gap;
    bit          word_taken;
    int          recv_wait;
    int          hold_left;
    bit          result_taken;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #100ms;
        $display("voxel_occupancy_marker test failed");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Quantise a Q.30 coordinate to its cell index, flooring toward minus infinity
    function automatic longint cell_index(input longint v);
        longint scaled;
        scaled = v * (STEPS - 3);
        return (scaled >>> 30) + 1;
    endfunction

    // Mark a 4x4x4 block; returns 1 when any cell fell outside the grid
    function automatic bit mark_cells(input longint ci, input longint cj, input longint ck);
        bit     dropped;
        longint i, j, k, lin;
        dropped = 1'b0;
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                for (int c = 0; c < 4; c++)
                begin
                    i = ci + a;
                    j = cj + b;
                    k = ck + c;
                    if (i < 0 || j < 0 || k < 0 || i >= GRID || j >= GRID || k >= GRID)
                    begin
                        dropped = 1'b1;
                        continue;
                    end
                    lin = (i * GRID + j) * GRID + k;
                    if (!occ_words[lin >> 6][lin & 63])
                    begin
                        occ_words[lin >> 6][lin & 63] = 1'b1;
                        occ_count = (occ_count + 1) & 22'h3FFFFF;
                    end
                end
        return dropped;
    endfunction

    function automatic int unsigned cell_number_of(input int i, input int j, input int k);
        longint      lin;
        int unsigned n;
        bit [63:0]   below;
        if (i >= GRID || j >= GRID || k >= GRID)
            return 0;
        lin = (longint'(i) * GRID + j) * GRID + k;
        if (!occ_words[lin >> 6][lin & 63])
            return 0;
        n = 0;
        for (longint w = 0; w < (lin >> 6); w++)
            n += $countones(occ_words[w]);
        below = (64'd1 << (lin & 63)) - 64'd1;
        n += $countones(occ_words[lin >> 6] & below);
        return (n + 1) & 22'h3FFFFF;
    endfunction

    // Work out the result of one accepted word and advance the shadow grid
    function automatic result_t grid_outcome(input item_t w);
        result_t r;
        longint  p [3];
        longint  d [3];
        bit      flag;
        r = '0;
        flag = 1'b0;
        case (w.cmd)
            CMD_ADD:
            begin
                p[0] = longint'(w.point_x) * 16384;
                p[1] = longint'(w.point_y) * 16384;
                p[2] = longint'(w.point_z) * 16384;
                d[0] = longint'(offset_dist) * longint'(w.normal_x);
                d[1] = longint'(offset_dist) * longint'(w.normal_y);
                d[2] = longint'(offset_dist) * longint'(w.normal_z);
                flag |= mark_cells(cell_index(p[0]), cell_index(p[1]), cell_index(p[2]));
                flag |= mark_cells(cell_index(p[0] + d[0]), cell_index(p[1] + d[1]),
                                   cell_index(p[2] + d[2]));
                flag |= mark_cells(cell_index(p[0] - 2 * d[0]), cell_index(p[1] - 2 * d[1]),
                                   cell_index(p[2] - 2 * d[2]));
            end
            CMD_QUERY:
                r.cell_number = NW'(cell_number_of(w.query_i, w.query_j, w.query_k));
            CMD_CLEAR:
            begin
                foreach (occ_words[n])
                    occ_words[n] = '0;
                occ_count = 0;
            end
            default: ;
        endcase
        r.occupied_total = NW'(occ_count);
        r.out_of_range = flag;
        return r;
    endfunction

    function automatic item_t noise_word();
        item_t        w;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w = raw[$bits(item_t)-1:0];
        return w;
    endfunction

    // Add with mostly small x so that later queries stay short
    function automatic item_t random_add();
        item_t w;
        w = noise_word();
        w.cmd = CMD_ADD;
        if ($urandom_range(0, 3) != 0)
            w.point_x = 16'($urandom_range(0, 4000));
        if ($urandom_range(0, 2) == 0)
        begin
            w.normal_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            w.normal_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            w.normal_z = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        add_cells.insert(add_cells.size(),
                         '{int'(cell_index(longint'(w.point_x) * 16384)),
                           int'(cell_index(longint'(w.point_y) * 16384)),
                           int'(cell_index(longint'(w.point_z) * 16384))});
        return w;
    endfunction

    // Query cells near earlier adds half the time, else mostly short random ones
    function automatic item_t random_query();
        item_t w;
        int    pick;
        w = noise_word();
        w.cmd = CMD_QUERY;
        if (add_cells.size() > 0 && $urandom_range(0, 1) == 0)
        begin
            pick = $urandom_range(0, add_cells.size() - 1);
            w.query_i = 7'(add_cells[pick][0] + $urandom_range(0, 3));
            w.query_j = 7'(add_cells[pick][1] + $urandom_range(0, 3));
            w.query_k = 7'(add_cells[pick][2] + $urandom_range(0, 3));
        end
        else if ($urandom_range(0, 9) != 0)
            w.query_i = 7'($urandom_range(0, 10));
        return w;
    endfunction

    function automatic item_t command_word(input logic [1:0] cmd);
        item_t w;
        w = noise_word();
        w.cmd = cmd;
        return w;
    endfunction

    task automatic write_offset(input logic [15:0] value);
        @(negedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= ADDR_OFFSET;
        pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        offset_dist = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until nothing is offered, queued or owed
    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (pending_words.size() != 0 || expected_results.size() != 0 || item_valid);
        repeat (200) @(posedge clk);
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Accept words and results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            expected_results.insert(expected_results.size(), grid_outcome(item));
            word_taken <= 1'b1;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            result_taken <= 1'b1;
            if (expected_results.size() == 0)
            begin
                report("result word with none expected", 1, 0);
            end
            else
            begin
                if (result.cell_number !== expected_results[0].cell_number)
                    report("cell_number", result.cell_number,
                           expected_results[0].cell_number);
                if (result.occupied_total !== expected_results[0].occupied_total)
                    report("occupied_total", result.occupied_total,
                           expected_results[0].occupied_total);
                if (result.out_of_range !== expected_results[0].out_of_range)
                    report("out_of_range", result.out_of_range,
                           expected_results[0].out_of_range);
                void'(expected_results.pop_front());
            end
        end
    end

    // Feed words from the pending queue, holding each until taken
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || word_taken))
        begin
            word_taken <= 1'b0;
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end
            else if (pending_words.size() > 0)
            begin
                item       <= pending_words.pop_front();
                item_valid <= 1'b1;
                send_gap   <= draw_gap();
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Stall results at random, with one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_taken <= 1'b0;
            if (hold_request && hold_left == 0)
            begin
                hold_request = 1'b0;
                hold_left   <= 40000;
                result_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left    <= hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (result_taken)
            begin
                recv_wait    <= draw_gap();
                result_stall <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait    <= recv_wait - 1;
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [15:0] offsets [6];
        item_t       w;
        int          roll;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        send_gap = 0;
        word_taken = 1'b0;
        recv_wait = 0;
        hold_left = 0;
        result_taken = 1'b0;
        occ_count = 0;
        offset_dist = 16'd655;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        offsets = '{16'd655, 16'd0, 16'd65535, 16'($urandom), 16'd3000, 16'd655};
        foreach (offsets[ph])
        begin
            write_offset(offsets[ph]);
            calm = (ph == 3);
            if (ph == 0)
            begin
                // Directed: extremes of points and normals, queries, unused command, clear
                w = command_word(CMD_QUERY);
                w.query_i = 7'd0; w.query_j = 7'd0; w.query_k = 7'd0;
                pending_words.insert(pending_words.size(), w);
                w = command_word(CMD_ADD);
                w.point_x = 16'd0; w.point_y = 16'd0; w.point_z = 16'd0;
                w.normal_x = 16'sh7FFF; w.normal_y = 16'sh7FFF; w.normal_z = 16'sh7FFF;
                pending_words.insert(pending_words.size(), w);
                w.point_x = 16'hFFFF; w.point_y = 16'hFFFF; w.point_z = 16'hFFFF;
                w.normal_x = -16'sh8000; w.normal_y = -16'sh8000; w.normal_z = -16'sh8000;
                pending_words.insert(pending_words.size(), w);
                w.point_x = 16'h8000; w.point_y = 16'h0100; w.point_z = 16'h4000;
                w.normal_x = 16'sd0; w.normal_y = 16'sd0; w.normal_z = 16'sd0;
                pending_words.insert(pending_words.size(), w);
                pending_words.insert(pending_words.size(), w);
                w = command_word(CMD_QUERY);
                w.query_i = 7'd1; w.query_j = 7'd1; w.query_k = 7'd1;
                pending_words.insert(pending_words.size(), w);
                w.query_i = 7'd4; w.query_j = 7'd4; w.query_k = 7'd4;
                pending_words.insert(pending_words.size(), w);
                w.query_i = 7'd0; w.query_j = 7'd127; w.query_k = 7'd127;
                pending_words.insert(pending_words.size(), w);
                pending_words.insert(pending_words.size(), command_word(CMD_UNUSED));
                pending_words.insert(pending_words.size(), command_word(CMD_CLEAR));
                w = command_word(CMD_QUERY);
                w.query_i = 7'd1; w.query_j = 7'd1; w.query_k = 7'd1;
                pending_words.insert(pending_words.size(), w);
                for (int n = 0; n < 6; n++)
                begin
                    pending_words.insert(pending_words.size(), random_add());
                    pending_words.insert(pending_words.size(), random_query());
                end
            end
            if (ph == 2)
                hold_request = 1'b1;
            for (int n = 0; n < 80; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 48)
                    pending_words.insert(pending_words.size(), random_add());
                else if (roll < 94)
                    pending_words.insert(pending_words.size(), random_query());
                else if (roll < 97)
                    pending_words.insert(pending_words.size(), command_word(CMD_UNUSED));
                else
                    pending_words.insert(pending_words.size(), command_word(CMD_CLEAR));
            end
            // Hold the sender until every result of this phase is back
            drain();
        end

        if (errors == 0)
            $display("voxel_occupancy_marker test passed");
        else
            $display("voxel_occupancy_marker test failed");
        $finish;
    end

endmodule
